// ===== design/lpc_pkg.sv =====
// Shared constants, types and codes of the line position centroid unit.
package lpc_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int MAX_SENSORS  = 8;
    localparam int NUM_SENSORS_DEF = 8;
    localparam int WEIGHT_W     = 8;
    localparam int ERR_W        = 8;
    localparam int CFG_W        = 32;
    localparam int CFG_ADDR_W   = 2;
    localparam int DEN_W        = 15;   // up to eight excesses of 4095
    localparam int NUM_W        = 24;   // signed weighted sum
    localparam int MAG_W        = 22;   // |weighted sum| stays below 2^22
    localparam int PROD_W       = SAMPLE_W + 1 + WEIGHT_W;
    localparam int DIV_STEPS    = 9;    // quotient magnitude never exceeds 128
    localparam int DSH_W        = DEN_W + DIV_STEPS - 1;
    localparam int REM_W        = DSH_W;
    localparam int CNT_W        = 4;

    // floor(x/3) == (x * 2731) >> 13 for every 12-bit x
    localparam int THIRD_RECIP  = 2731;
    localparam int THIRD_SHIFT  = 13;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX         = 12'd4095;
    localparam logic                WHITE_RESET        = 1'b1;
    localparam logic [SAMPLE_W-1:0] MIN_CONTRAST_RESET = 12'd800;
    localparam logic [CFG_W-1:0]    WEIGHTS_LOW_RESET  = 32'hFBEC_E2D8;
    localparam logic [CFG_W-1:0]    WEIGHTS_HIGH_RESET = 32'h281E_1405;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WHITE        = 2'd0,
        CFG_MIN_CONTRAST = 2'd1,
        CFG_WEIGHTS_LOW  = 2'd2,
        CFG_WEIGHTS_HIGH = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_THRESH,
        ST_ACCUM,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic thresh;
        logic accum;
        logic div_init;
        logic div_step;
        logic finish;
        logic fresh;
    } cmd_t;

    typedef struct packed {
        logic conv_ok;
        logic contrast_ok;
        logic den_zero;
        logic out_free;
    } status_t;

endpackage

// ===== design/lpc_datapath.sv =====
// Datapath: sample store, min/max scan, threshold, weighted sums, serial divider, output register.
module lpc_datapath #(
    parameter int NUM_SENSORS = lpc_pkg::NUM_SENSORS_DEF,
    parameter int CHAN_W      = $clog2(NUM_SENSORS)
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic [lpc_pkg::MAX_SENSORS*lpc_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic                                        s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [lpc_pkg::ERR_W-1:0]                   m_tdata,
    output logic                                        m_tuser,
    input  logic                                        cfg_we,
    input  logic [lpc_pkg::CFG_ADDR_W-1:0]              cfg_addr,
    input  logic [lpc_pkg::CFG_W-1:0]                   cfg_wdata,
    input  lpc_pkg::cmd_t                               cmd,
    input  logic [CHAN_W-1:0]                           chan,
    output lpc_pkg::status_t                            status
);

    localparam int SW = lpc_pkg::SAMPLE_W;

    logic                           white_reg;
    logic [SW-1:0]                  min_contrast_reg;
    logic [lpc_pkg::CFG_W-1:0]      weights_low_reg;
    logic [lpc_pkg::CFG_W-1:0]      weights_high_reg;

    logic [SW-1:0]                  val_reg [NUM_SENSORS];
    logic                           conv_reg;
    logic [SW-1:0]                  hi_reg;
    logic [SW-1:0]                  lo_reg;
    logic [SW-1:0]                  thr_reg;
    logic signed [lpc_pkg::NUM_W-1:0] num_reg;
    logic [lpc_pkg::DEN_W-1:0]      den_reg;
    logic [lpc_pkg::REM_W-1:0]      rem_reg;
    logic [lpc_pkg::DSH_W-1:0]      dsh_reg;
    logic [lpc_pkg::DIV_STEPS-1:0]  quo_reg;
    logic                           neg_reg;
    logic [lpc_pkg::ERR_W-1:0]      held_reg;
    logic                           m_tvalid_reg;
    logic [lpc_pkg::ERR_W-1:0]      m_tdata_reg;
    logic                           m_tuser_reg;

    logic [SW-1:0]                  cur;
    logic [SW-1:0]                  spread;
    logic [2*SW-1:0]                third_prod;
    logic [SW-1:0]                  excess;
    logic [2*lpc_pkg::CFG_W-1:0]    weights;
    logic signed [lpc_pkg::WEIGHT_W-1:0] weight;
    logic signed [lpc_pkg::PROD_W-1:0]   prod;
    logic [lpc_pkg::NUM_W-1:0]      num_mag;
    logic [lpc_pkg::ERR_W-1:0]      new_err;

    assign cur        = val_reg[chan];
    assign spread     = hi_reg - lo_reg;
    assign third_prod = spread * SW'(lpc_pkg::THIRD_RECIP);
    assign excess     = (cur > thr_reg) ? cur - thr_reg : '0;
    assign weights    = {weights_high_reg, weights_low_reg};
    assign weight     = $signed(weights[lpc_pkg::WEIGHT_W*chan +: lpc_pkg::WEIGHT_W]);
    assign prod       = $signed({1'b0, excess}) * weight;
    assign num_mag    = num_reg[lpc_pkg::NUM_W-1] ? -num_reg : num_reg;
    assign new_err    = neg_reg ? lpc_pkg::ERR_W'(-quo_reg) : lpc_pkg::ERR_W'(quo_reg);

    assign status.conv_ok     = conv_reg;
    assign status.contrast_ok = (spread >= min_contrast_reg);
    assign status.den_zero    = (den_reg == '0);
    assign status.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            white_reg        <= lpc_pkg::WHITE_RESET;
            min_contrast_reg <= lpc_pkg::MIN_CONTRAST_RESET;
            weights_low_reg  <= lpc_pkg::WEIGHTS_LOW_RESET;
            weights_high_reg <= lpc_pkg::WEIGHTS_HIGH_RESET;
        end else if (cfg_we) begin
            unique case (lpc_pkg::cfg_idx_t'(cfg_addr))
                lpc_pkg::CFG_WHITE:        white_reg        <= cfg_wdata[0];
                lpc_pkg::CFG_MIN_CONTRAST: min_contrast_reg <= cfg_wdata[SW-1:0];
                lpc_pkg::CFG_WEIGHTS_LOW:  weights_low_reg  <= cfg_wdata;
                lpc_pkg::CFG_WEIGHTS_HIGH: weights_high_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                val_reg[i] <= white_reg ? s_tdata[i*SW +: SW]
                                        : lpc_pkg::SAMPLE_MAX - s_tdata[i*SW +: SW];
            end
            conv_reg <= s_tuser;
            hi_reg   <= '0;
            lo_reg   <= lpc_pkg::SAMPLE_MAX;
        end
        if (cmd.scan) begin
            if (cur > hi_reg) hi_reg <= cur;
            if (cur < lo_reg) lo_reg <= cur;
        end
        if (cmd.thresh) begin
            thr_reg <= lo_reg + SW'(third_prod[2*SW-1:lpc_pkg::THIRD_SHIFT]);
            num_reg <= '0;
            den_reg <= '0;
        end
        if (cmd.accum) begin
            num_reg <= num_reg + {{(lpc_pkg::NUM_W-lpc_pkg::PROD_W){prod[lpc_pkg::PROD_W-1]}},
                                  prod};
            den_reg <= den_reg + lpc_pkg::DEN_W'(excess);
        end
        if (cmd.div_init) begin
            rem_reg <= lpc_pkg::REM_W'(num_mag[lpc_pkg::MAG_W-1:0]);
            dsh_reg <= {den_reg, (lpc_pkg::DIV_STEPS-1)'(0)};
            quo_reg <= '0;
            neg_reg <= num_reg[lpc_pkg::NUM_W-1];
        end
        if (cmd.div_step) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[lpc_pkg::DIV_STEPS-2:0], 1'b1};
            end else begin
                quo_reg <= {quo_reg[lpc_pkg::DIV_STEPS-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.finish) begin
            m_tdata_reg <= cmd.fresh ? new_err : held_reg;
            m_tuser_reg <= cmd.fresh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.finish && cmd.fresh) held_reg <= new_err;
            if (cmd.finish)              m_tvalid_reg <= 1'b1;
            else if (m_tready)           m_tvalid_reg <= 1'b0;
        end
    end

endmodule

// ===== design/lpc_controller.sv =====
// Controller: sequences capture, scan, threshold, accumulation, division and result hand-off.
module lpc_controller #(
    parameter int NUM_SENSORS = lpc_pkg::NUM_SENSORS_DEF,
    parameter int CHAN_W      = $clog2(NUM_SENSORS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lpc_pkg::status_t  status,
    output lpc_pkg::cmd_t     cmd,
    output logic [CHAN_W-1:0] chan
);

    localparam logic [lpc_pkg::CNT_W-1:0] LAST_CHAN = lpc_pkg::CNT_W'(NUM_SENSORS - 1);
    localparam logic [lpc_pkg::CNT_W-1:0] LAST_STEP = lpc_pkg::CNT_W'(lpc_pkg::DIV_STEPS - 1);

    lpc_pkg::state_t             state_reg, state_next;
    logic [lpc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        fresh_reg, fresh_next;

    assign chan = cnt_reg[CHAN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            fresh_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fresh_reg <= fresh_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fresh_next = fresh_reg;
        unique case (state_reg)
            lpc_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (s_tvalid) state_next = lpc_pkg::ST_SCAN;
            end
            lpc_pkg::ST_SCAN: begin
                if (cnt_reg == LAST_CHAN) begin
                    cnt_next   = '0;
                    state_next = lpc_pkg::ST_THRESH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            lpc_pkg::ST_THRESH: begin
                if (!status.conv_ok || !status.contrast_ok) begin
                    fresh_next = 1'b0;
                    state_next = lpc_pkg::ST_FINISH;
                end else begin
                    state_next = lpc_pkg::ST_ACCUM;
                end
            end
            lpc_pkg::ST_ACCUM: begin
                if (cnt_reg == LAST_CHAN) begin
                    cnt_next   = '0;
                    state_next = lpc_pkg::ST_CHECK;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            lpc_pkg::ST_CHECK: begin
                if (status.den_zero) begin
                    fresh_next = 1'b0;
                    state_next = lpc_pkg::ST_FINISH;
                end else begin
                    state_next = lpc_pkg::ST_DIVIDE;
                end
            end
            lpc_pkg::ST_DIVIDE: begin
                if (cnt_reg == LAST_STEP) begin
                    fresh_next = 1'b1;
                    state_next = lpc_pkg::ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            lpc_pkg::ST_FINISH: begin
                if (status.out_free) state_next = lpc_pkg::ST_IDLE;
            end
            default: state_next = lpc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            lpc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            lpc_pkg::ST_SCAN:   cmd.scan     = 1'b1;
            lpc_pkg::ST_THRESH: cmd.thresh   = 1'b1;
            lpc_pkg::ST_ACCUM:  cmd.accum    = 1'b1;
            lpc_pkg::ST_CHECK:  cmd.div_init = !status.den_zero;
            lpc_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
            lpc_pkg::ST_FINISH: begin
                cmd.finish = status.out_free;
                cmd.fresh  = fresh_reg;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== design/line_position_centroid_unit.sv =====
// Top level of the line position centroid unit: controller and datapath.
// One item is taken at a time. Each item is scanned for min/max one channel per cycle;
// when the conversion failed or the contrast is too low, accumulation and division are
// skipped. Otherwise the weighted sums are accumulated one channel per cycle, and unless
// no sample lies above the threshold the nine-step restoring divider forms the centroid.
// The result register lets the next item be taken while a result waits on m_tready.
// Configuration is to be written through cfg_we/cfg_addr/cfg_wdata only while the unit
// is idle; the unit itself does not enforce this.
module line_position_centroid_unit #(
    parameter int NUM_SENSORS = lpc_pkg::NUM_SENSORS_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    // sample_0 .. sample_7, 12 bits each, sample_0 lowest
    input  logic [lpc_pkg::MAX_SENSORS*lpc_pkg::SAMPLE_W-1:0] s_tdata,
    // conversion_ok
    input  logic                                              s_tuser,
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    // position_error (signed)
    output logic [lpc_pkg::ERR_W-1:0]                         m_tdata,
    // line_valid
    output logic                                              m_tuser,
    input  logic                                              cfg_we,
    input  logic [lpc_pkg::CFG_ADDR_W-1:0]                    cfg_addr,
    input  logic [lpc_pkg::CFG_W-1:0]                         cfg_wdata
);

    localparam int CHAN_W = $clog2(NUM_SENSORS);

    lpc_pkg::cmd_t       cmd;
    lpc_pkg::status_t    status;
    logic [CHAN_W-1:0]   chan;

    lpc_controller #(
        .NUM_SENSORS (NUM_SENSORS),
        .CHAN_W      (CHAN_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .chan     (chan)
    );

    lpc_datapath #(
        .NUM_SENSORS (NUM_SENSORS),
        .CHAN_W      (CHAN_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .chan      (chan),
        .status    (status)
    );

endmodule

// ===== design/lpc_checker.sv =====
// Port-level checks of the line position centroid unit, bound to the top level.
module lpc_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [lpc_pkg::ERR_W-1:0] m_tdata,
    input logic                      m_tuser
);

    logic [lpc_pkg::ERR_W-1:0] last_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            last_err_reg <= m_tdata;
        end
    end

    // no result straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // a held result repeats the last delivered error
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser |-> m_tdata == last_err_reg)
        else $error("held error differs from last delivered error");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind line_position_centroid_unit lpc_checker u_lpc_checker (.*);
